### rtl/core/egcd_pkg.sv
// ----------------------------------------------------------------------------
// egcd_pkg: shared types and constants for the extended GCD block
// Operand and coefficient widths, stream packing widths and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package egcd_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int OPND_W      = DATA_WIDTH - 1;
  localparam int COEF_W      = DATA_WIDTH;
  // one quotient bit per divider step
  localparam int DIV_STEPS   = OPND_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int IN_TDATA_W  = ((2 * OPND_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OPND_W + 2 * COEF_W + 7) / 8) * 8;

  typedef logic [OPND_W-1:0]        opnd_t;
  typedef logic [COEF_W-1:0]        coef_t;
  typedef logic signed [COEF_W-1:0] scoef_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // take a new operand pair
    logic div_init;  // start a division r0 / r1
    logic div_step;  // one restoring division step
    logic mul;       // form q*s1 and q*t1
    logic upd;       // advance the remainder and coefficient sequences
  } egcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic r1_zero;   // current divisor is zero: the run is over
  } egcd_stat_t;

endpackage

### rtl/core/egcd_dp.sv
// ----------------------------------------------------------------------------
// egcd_dp: extended Euclid datapath
// Remainder and coefficient registers, a bit-serial restoring divider and
// one multiply-subtract round per quotient.
// ----------------------------------------------------------------------------
module egcd_dp
  import egcd_pkg::*;
(
  input  logic       clk,
  input  egcd_cmd_t  cmd,
  input  opnd_t      in_a,
  input  opnd_t      in_b,
  output egcd_stat_t stat,
  output opnd_t      res_divisor,
  output scoef_t     res_coef_a,
  output scoef_t     res_coef_b
);

  opnd_t r0, r1;
  coef_t s0, s1, t0, t1;
  logic  swap;

  // divider state
  opnd_t rem, dvd, quo;
  // products of the current round
  coef_t ps, pt;

  logic [OPND_W:0] trial;
  logic [OPND_W:0] diff;
  logic            fits;
  coef_t           qx;

  assign trial = {rem, dvd[OPND_W-1]};
  assign diff  = trial - {1'b0, r1};
  assign fits  = (trial >= {1'b0, r1});
  assign qx    = COEF_W'(quo);

  // remainder and coefficient sequences
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      swap <= (in_b > in_a);
      if (in_b > in_a) begin
        r0 <= in_b;
        r1 <= in_a;
      end else begin
        r0 <= in_a;
        r1 <= in_b;
      end
      s0 <= COEF_W'(1);
      s1 <= '0;
      t0 <= '0;
      t1 <= COEF_W'(1);
    end else if (cmd.upd) begin
      r0 <= r1;
      r1 <= rem;
      s0 <= s1;
      s1 <= s0 - ps;
      t0 <= t1;
      t1 <= t0 - pt;
    end
  end

  // serial restoring divider, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= '0;
      dvd <= r0;
      quo <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[OPND_W-2:0], 1'b0};
      quo <= {quo[OPND_W-2:0], fits};
      rem <= fits ? diff[OPND_W-1:0] : trial[OPND_W-1:0];
    end
  end

  // products, registered before the subtract (kept modulo 2^COEF_W)
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      ps <= qx * s1;
      pt <= qx * t1;
    end
  end

  assign stat.r1_zero = (r1 == '0);
  assign res_divisor  = r0;
  // swap the coefficients back when the operands were exchanged
  assign res_coef_a   = swap ? scoef_t'(t0) : scoef_t'(s0);
  assign res_coef_b   = swap ? scoef_t'(s0) : scoef_t'(t0);

endmodule

### rtl/core/egcd_ctrl.sv
// ----------------------------------------------------------------------------
// egcd_ctrl: extended Euclid sequencer
// Runs check / divide / multiply / update rounds until the divisor is zero,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module egcd_ctrl
  import egcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_free,
  output logic       out_load,
  input  egcd_stat_t stat,
  output egcd_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_MUL   = 6'b001000,
    S_UPD   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;

  // next state and commands
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.r1_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_CHECK;
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

### rtl/core/extended_gcd_bezout.sv
// ----------------------------------------------------------------------------
// extended_gcd_bezout: GCD with signed Bezout coefficients
// Each item runs one round per Euclid quotient (up to 44) between input and
// result transfer; a round is check, 31-step serial divide, multiply, update.
// Throughput: one item at a time; the next item is taken once the result
// sits in the output register, while that result waits for its transfer.
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register.
// ----------------------------------------------------------------------------
module extended_gcd_bezout
  import egcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // operand_a, operand_b, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // divisor, coef_a, coef_b, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  egcd_cmd_t  cmd;
  egcd_stat_t stat;
  logic       out_free, out_load;
  opnd_t      res_divisor, divisor;
  scoef_t     res_coef_a, res_coef_b, coef_a, coef_b;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  egcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .out_load (out_load),
    .stat     (stat),
    .cmd      (cmd)
  );

  egcd_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .in_a        (s_axis_tdata[OPND_W-1:0]),
    .in_b        (s_axis_tdata[2*OPND_W-1:OPND_W]),
    .stat        (stat),
    .res_divisor (res_divisor),
    .res_coef_a  (res_coef_a),
    .res_coef_b  (res_coef_b)
  );

  // output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      divisor <= res_divisor;
      coef_a  <= res_coef_a;
      coef_b  <= res_coef_b;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({coef_b, coef_a, divisor});

endmodule
